/* rtl/lbb_pkg.sv */
// Shared types, codes and constants for the LED breathing / blink controller.
// No dependencies; imported by lbb_step, lbb_core and the top level.
package lbb_pkg;

    localparam int LEVEL_FRAC_BITS_DEF = 8;     // default Q format of the duty level
    localparam int LEVEL_W             = 24;    // duty level width, two's complement
    localparam int CFG_W               = 8;     // width of each config register
    localparam int FLASH_T_W           = 16;    // flash timer width, wraps
    localparam int GROUP_W             = 4;     // flash group counter width, wraps
    localparam int PAT_MS_W            = 10;    // width of pattern timing constants
    localparam int FULL_LEVEL          = 20;    // full-on duty, integer part
    localparam int BREATH_HALF_MS      = 1000;  // step divisor
    localparam int DUTY_RES_RST        = 20;
    localparam int PATTERN_PERIOD_RST  = 20;

    // config register indexes
    localparam logic CFG_DUTY_RES       = 1'b0;
    localparam logic CFG_PATTERN_PERIOD = 1'b1;

    typedef enum logic [1:0] {
        MODE_PWM     = 2'd0,
        MODE_PATTERN = 2'd1,
        MODE_WARN_WR = 2'd2,
        MODE_HOLD    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        WARN_NORMAL    = 2'd0,
        WARN_LOW_BATT  = 2'd1,
        WARN_GYRO_CAL  = 2'd2,
        WARN_ACCEL_CAL = 2'd3
    } warn_t;

    typedef struct packed {
        mode_t mode;
        logic  armed;
        warn_t warn_request;
    } lbb_item_t;

    typedef struct packed {
        logic  red_on;
        logic  blue_on;
        warn_t warn_now;
        logic  cycle_done;
    } lbb_result_t;

    // live configuration plus the derived breath step (zero-extended)
    typedef struct packed {
        logic [CFG_W-1:0]   duty_res;
        logic [CFG_W-1:0]   pattern_period;
        logic [LEVEL_W-1:0] breath_step;
    } lbb_cfg_t;

    typedef struct packed {
        logic [GROUP_W-1:0]  groups;
        logic [PAT_MS_W-1:0] on_ms;
        logic [PAT_MS_W-1:0] off_ms;
        logic [PAT_MS_W-1:0] gap_ms;
    } flash_pat_t;

    // Flash pattern per warning code; the normal entry is the armed pattern.
    function automatic flash_pat_t flash_pat(warn_t code);
        flash_pat_t p;
        unique case (code)
            WARN_NORMAL:    p = '{groups: 4'd2,  on_ms: 10'd100, off_ms: 10'd100, gap_ms: 10'd500};
            WARN_LOW_BATT:  p = '{groups: 4'd1,  on_ms: 10'd80,  off_ms: 10'd80,  gap_ms: 10'd0};
            WARN_GYRO_CAL:  p = '{groups: 4'd6,  on_ms: 10'd100, off_ms: 10'd100, gap_ms: 10'd0};
            WARN_ACCEL_CAL: p = '{groups: 4'd12, on_ms: 10'd100, off_ms: 10'd100, gap_ms: 10'd0};
            default:        p = '{groups: 4'd2,  on_ms: 10'd100, off_ms: 10'd100, gap_ms: 10'd500};
        endcase
        return p;
    endfunction

endpackage

/* rtl/led_breath_blink_pwm_controller_top.sv */
// Top level of the status LED breathing / blink PWM controller.
// Depends on lbb_pkg, lbb_step (config and breath step) and lbb_core (state update).
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tuser: mode; s_tdata: armed, warn_request
//  m_      | out | m_tvalid/m_tready  | m_tdata: red_on, blue_on, warn_now, cycle_done
//  cfg_    | in  | cfg_wr_en          | cfg_wr_index, cfg_wr_data (no read-back)
//
// Flow: one request per clock sustained while m_tready stays high; a request is held
// in the input register, is processed by lbb_core in a single pass once the output
// register can take the result; the result is registered in the output register,
// which drives m_tvalid. lbb_core updates its state once per processed request.
// Reset (aresetn, synchronous, active low) clears handshake state, config to 20/20,
// duty level to full-on and all LED/pattern state. The breath step follows a config
// write through prod_reg and then step_reg, so it lags the config registers.
// Stalls: with the output register full and m_tready low, one more request is held
// in the input register; s_tready drops only when both are occupied.
module led_breath_blink_pwm_controller_top
    import lbb_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    // request channel
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,    // [0] armed, [2:1] warn_request, [7:3] zero
    input  logic [1:0]       s_tuser,    // [1:0] mode
    // result channel
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,    // [0] red_on, [1] blue_on, [3:2] warn_now,
                                         // [4] cycle_done, [7:5] zero
    // config write port
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_index,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    logic        in_valid_reg, in_valid_next;
    lbb_item_t   in_item_reg;
    logic        out_valid_reg, out_valid_next;
    lbb_result_t out_result_reg;

    logic        s_accept;
    logic        advance;     // output register can take a result
    logic        proc_en;     // input register drains into core this cycle
    lbb_cfg_t    cfg;
    lbb_result_t core_result;

    assign advance  = !out_valid_reg || m_tready;
    assign proc_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (proc_en) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (proc_en) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.mode         <= mode_t'(s_tuser);
            in_item_reg.armed        <= s_tdata[0];
            in_item_reg.warn_request <= warn_t'(s_tdata[2:1]);
        end
        if (proc_en) begin
            out_result_reg <= core_result;
        end
    end

    lbb_step #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_step (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    lbb_core #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .proc_en (proc_en),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_result_reg.cycle_done, out_result_reg.warn_now,
                       out_result_reg.blue_on, out_result_reg.red_on};

    // a held request is not dropped while the result side stalls
    a_hold_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |=> in_valid_reg)
        else $error("request lost while output stalled");

    // every processed request produces a result
    a_proc_out: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_en |=> m_tvalid)
        else $error("processed request gave no result");

    // only pattern ticks may report a completed flash cycle
    a_done_pattern: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_en && in_item_reg.mode != MODE_PATTERN) |=> !out_result_reg.cycle_done)
        else $error("cycle_done on a non-pattern request");

endmodule

/* rtl/lbb_step.sv */
// Config registers and breath step: step = round(res * period * 2^F / 1000).
// Depends on lbb_pkg. Divide by 1000 is a shift by 3 and a reciprocal multiply by 1/125.
module lbb_step
    import lbb_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_index,
    input  logic [CFG_W-1:0] cfg_wr_data,
    output lbb_cfg_t         cfg
);

    localparam int PROD_W    = 2 * CFG_W;
    localparam int Y_W       = PROD_W + LEVEL_FRAC_BITS;   // prod<<F + 500 fits here
    localparam int DIV_SHIFT = 3;
    localparam int DIV_ODD   = BREATH_HALF_MS >> DIV_SHIFT;
    localparam int ODD_BITS  = $clog2(DIV_ODD);
    localparam int Z_W       = Y_W - DIV_SHIFT;
    localparam int K         = Z_W + ODD_BITS;
    localparam int RECIP_W   = K - ODD_BITS + 1;
    localparam int MUL_W     = Z_W + RECIP_W;
    localparam int STEP_W    = LEVEL_FRAC_BITS + 7;
    localparam logic [63:0] RECIP = ((64'd1 << K) + 64'(DIV_ODD - 1)) / 64'(DIV_ODD);
    localparam int STEP_RST =
        ((DUTY_RES_RST * PATTERN_PERIOD_RST << LEVEL_FRAC_BITS) + BREATH_HALF_MS / 2)
        / BREATH_HALF_MS;

    logic [CFG_W-1:0]  duty_res_reg, duty_res_next;
    logic [CFG_W-1:0]  period_reg, period_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CFG_W-1:0]  mul_a, mul_b;
    logic [Y_W-1:0]    y;
    logic [Z_W-1:0]    z;
    logic [MUL_W-1:0]  quot_full;

    // product tracks the registers as they are written
    always_comb begin
        mul_a         = duty_res_reg;
        mul_b         = period_reg;
        duty_res_next = duty_res_reg;
        period_next   = period_reg;
        if (cfg_wr_en) begin
            if (cfg_wr_index == CFG_DUTY_RES) begin
                mul_a         = cfg_wr_data;
                duty_res_next = cfg_wr_data;
            end else begin
                mul_b       = cfg_wr_data;
                period_next = cfg_wr_data;
            end
        end
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_comb begin
        y         = (Y_W'(prod_reg) << LEVEL_FRAC_BITS) + Y_W'(BREATH_HALF_MS / 2);
        z         = y[Y_W-1:DIV_SHIFT];
        quot_full = MUL_W'(z) * MUL_W'(RECIP[RECIP_W-1:0]);
        step_next = quot_full[K +: STEP_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_res_reg <= CFG_W'(DUTY_RES_RST);
            period_reg   <= CFG_W'(PATTERN_PERIOD_RST);
            prod_reg     <= PROD_W'(DUTY_RES_RST * PATTERN_PERIOD_RST);
            step_reg     <= STEP_W'(STEP_RST);
        end else begin
            duty_res_reg <= duty_res_next;
            period_reg   <= period_next;
            prod_reg     <= prod_next;
            step_reg     <= step_next;
        end
    end

    assign cfg.duty_res       = duty_res_reg;
    assign cfg.pattern_period = period_reg;
    assign cfg.breath_step    = LEVEL_W'(step_reg);

endmodule

/* rtl/lbb_core.sv */
// State and single-pass update for one item: PWM, breathing, flash patterns, warning code writes.
// Depends on lbb_pkg; takes live config from lbb_step.
module lbb_core
    import lbb_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        proc_en,
    input  lbb_item_t   item,
    input  lbb_cfg_t    cfg,
    output lbb_result_t result
);

    localparam logic signed [LEVEL_W-1:0] FULL_Q    = LEVEL_W'(FULL_LEVEL << LEVEL_FRAC_BITS);
    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = {1'b0, {(LEVEL_W-1){1'b1}}};
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};

    logic [CFG_W-1:0]            pwm_count_reg, pwm_count_next;
    logic signed [LEVEL_W-1:0]   duty_level_reg, duty_level_next;
    logic                        falling_reg, falling_next;
    logic [FLASH_T_W-1:0]        flash_time_reg, flash_time_next;
    logic [GROUP_W-1:0]          group_reg, group_next;
    logic                        red_reg, red_next;
    logic                        blue_reg, blue_next;
    warn_t                       warn_reg, warn_next;

    logic [LEVEL_W-1:0]          cnt_q;
    logic                        lit;
    logic [CFG_W:0]              cnt_inc;
    logic signed [LEVEL_W:0]     breath_sum;
    logic signed [LEVEL_W-1:0]   breath_sat;
    flash_pat_t                  pat;
    logic [FLASH_T_W-1:0]        on_end;
    logic [FLASH_T_W-1:0]        t_mid;
    logic                        done;

    always_comb begin
        pwm_count_next  = pwm_count_reg;
        duty_level_next = duty_level_reg;
        falling_next    = falling_reg;
        flash_time_next = flash_time_reg;
        group_next      = group_reg;
        red_next        = red_reg;
        blue_next       = blue_reg;
        warn_next       = warn_reg;
        done            = 1'b0;

        // PWM compare and counter wrap
        cnt_q   = LEVEL_W'(pwm_count_reg) << LEVEL_FRAC_BITS;
        lit     = $signed(cnt_q) < duty_level_reg;
        cnt_inc = {1'b0, pwm_count_reg} + (CFG_W+1)'(1);

        // breathing ramp, saturating
        if (falling_reg) begin
            breath_sum = {duty_level_reg[LEVEL_W-1], duty_level_reg}
                       - $signed({1'b0, cfg.breath_step});
        end else begin
            breath_sum = {duty_level_reg[LEVEL_W-1], duty_level_reg}
                       + $signed({1'b0, cfg.breath_step});
        end
        if (breath_sum[LEVEL_W] != breath_sum[LEVEL_W-1]) begin
            breath_sat = breath_sum[LEVEL_W] ? LEVEL_MIN : LEVEL_MAX;
        end else begin
            breath_sat = breath_sum[LEVEL_W-1:0];
        end

        // flash pattern for the current code
        pat    = flash_pat(warn_reg);
        on_end = FLASH_T_W'(pat.on_ms) + FLASH_T_W'(pat.off_ms);
        t_mid  = flash_time_reg;

        unique case (item.mode)
            MODE_PWM: begin
                if (item.armed) begin
                    red_next = lit;
                end else begin
                    blue_next = lit;
                end
                pwm_count_next = (cnt_inc >= {1'b0, cfg.duty_res}) ? '0 : cnt_inc[CFG_W-1:0];
            end
            MODE_PATTERN: begin
                if (warn_reg == WARN_NORMAL && !item.armed) begin
                    duty_level_next = breath_sat;
                    if (!falling_reg && breath_sat > FULL_Q) begin
                        falling_next = 1'b1;
                    end else if (falling_reg && breath_sat < 0) begin
                        falling_next = 1'b0;
                    end
                end else begin
                    if (group_reg < pat.groups) begin
                        if (flash_time_reg < FLASH_T_W'(pat.on_ms)) begin
                            duty_level_next = FULL_Q;
                        end else if (flash_time_reg < on_end) begin
                            duty_level_next = '0;
                        end
                        if (flash_time_reg >= on_end) begin
                            group_next = group_reg + GROUP_W'(1);
                            t_mid      = '0;
                        end
                    end else begin
                        if (flash_time_reg < FLASH_T_W'(pat.gap_ms)) begin
                            duty_level_next = '0;
                        end else begin
                            group_next = '0;
                            t_mid      = '0;
                            done       = 1'b1;
                        end
                    end
                    flash_time_next = t_mid + FLASH_T_W'(cfg.pattern_period);
                    // calibration codes end with their flash cycle
                    if (done && (warn_reg == WARN_GYRO_CAL || warn_reg == WARN_ACCEL_CAL)) begin
                        warn_next = WARN_NORMAL;
                    end
                end
            end
            MODE_WARN_WR: begin
                warn_next = item.warn_request;
            end
            MODE_HOLD: begin
            end
            default: begin
            end
        endcase

        result.red_on     = red_next;
        result.blue_on    = blue_next;
        result.warn_now   = warn_next;
        result.cycle_done = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_count_reg  <= '0;
            duty_level_reg <= FULL_Q;
            falling_reg    <= 1'b0;
            flash_time_reg <= '0;
            group_reg      <= '0;
            red_reg        <= 1'b0;
            blue_reg       <= 1'b0;
            warn_reg       <= WARN_NORMAL;
        end else if (proc_en) begin
            pwm_count_reg  <= pwm_count_next;
            duty_level_reg <= duty_level_next;
            falling_reg    <= falling_next;
            flash_time_reg <= flash_time_next;
            group_reg      <= group_next;
            red_reg        <= red_next;
            blue_reg       <= blue_next;
            warn_reg       <= warn_next;
        end
    end

endmodule
